/* src/dhcpslr_pkg.sv */
// Package for the single-lease DHCP responder: sizes, register indexes,
// reply constants and option codes. No dependencies.
package dhcpslr_pkg;

    localparam int OPTION_WINDOW = 64;

    localparam int HDR_LEN  = 240;
    localparam int POS_MAX  = HDR_LEN + OPTION_WINDOW;
    localparam int POS_W    = $clog2(POS_MAX + 1);

    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_SERVER_ADDR = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLIENT_ADDR = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SUBNET_MASK = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEASE_SECS  = 8'd3;

    localparam logic [31:0] RST_SERVER_ADDR = 32'hC0A8_0701;
    localparam logic [31:0] RST_CLIENT_ADDR = 32'hC0A8_0702;
    localparam logic [31:0] RST_SUBNET_MASK = 32'hFFFF_FF00;
    localparam logic [31:0] RST_LEASE_SECS  = 32'd86400;

    localparam logic [31:0] MAGIC_COOKIE = 32'h6382_5363;

    localparam logic [7:0] OP_BOOTREQUEST = 8'd1;
    localparam logic [7:0] OP_BOOTREPLY   = 8'd2;
    localparam logic [7:0] HTYPE_ETHER    = 8'd1;
    localparam logic [7:0] HLEN_ETHER     = 8'd6;

    localparam logic [7:0] OPT_PAD         = 8'd0;
    localparam logic [7:0] OPT_SUBNET_MASK = 8'd1;
    localparam logic [7:0] OPT_LEASE_TIME  = 8'd51;
    localparam logic [7:0] OPT_MSG_TYPE    = 8'd53;
    localparam logic [7:0] OPT_SERVER_ID   = 8'd54;
    localparam logic [7:0] OPT_END         = 8'd255;
    localparam logic [7:0] OPT_LEN4        = 8'd4;
    localparam logic [7:0] OPT_LEN1        = 8'd1;

    localparam logic [7:0] MSG_DISCOVER = 8'd1;
    localparam logic [7:0] MSG_OFFER    = 8'd2;
    localparam logic [7:0] MSG_REQUEST  = 8'd3;
    localparam logic [7:0] MSG_ACK      = 8'd5;

    localparam int REPLY_WORDS = 33;
    localparam int EMIT_W      = 6;
    localparam logic [EMIT_W-1:0] LAST_WORD_IDX = EMIT_W'(REPLY_WORDS - 1);
    localparam logic [3:0] VB_FULL = 4'd8;
    localparam logic [3:0] VB_LAST = 4'd6;

endpackage

/* src/dhcp_single_lease_responder_core.sv */
// DHCP single-lease responder, top level: header capture, option walk,
// client hardware address store and reply sequencer. Uses dhcpslr_pkg.
//
// Request bytes are taken one per clock cycle. When the last byte of a
// valid DISCOVER or REQUEST is taken, the 33-word OFFER or ACK is loaded
// into the output register one word per cycle while the output is not
// stalled; the input stays stalled until the final word is loaded, and the next
// request may start in the cycle after that word is loaded. Requests
// that draw no reply cost nothing extra. The client hardware address sits
// in a 4-entry, 64-bit synchronous store laid out as reply words 3 to 5,
// read with the next word index, so each entry is ready for the word that needs it.
module dhcp_single_lease_responder_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [7:0]                          i_payload_byte,
    input  logic                                i_end_of_packet,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [63:0]                         o_reply_word,
    output logic [3:0]                          o_valid_bytes,
    output logic                                o_last_word,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [dhcpslr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [31:0]                         i_cfg_data
);
    import dhcpslr_pkg::*;

    typedef enum logic [1:0] {
        PH_CODE,
        PH_LEN,
        PH_VAL53,
        PH_SKIP
    } t_opt_phase;

    logic [31:0]       r_server, r_client, r_mask, r_lease;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic              r_hdr_ok, n_hdr_ok;
    logic [31:0]       r_xid;
    logic [15:0]       r_flags;
    logic [7:0]        r_req_type, n_req_type;
    t_opt_phase        r_phase, n_phase;
    logic [7:0]        r_skip, n_skip;
    logic              r_done, n_done;
    logic [63:0]       r_hw_sr, n_hw_sr;
    logic [7:0]        r_reply_type;
    logic              r_emit_active;
    logic [EMIT_W-1:0] r_emit_idx;
    logic              r_out_valid;
    logic [63:0]       r_out_word;
    logic [3:0]        r_out_vb;
    logic              r_out_last;

    logic [63:0]       hw_mem [4];
    logic [63:0]       r_hw_rd;
    logic              mem_we;
    logic [1:0]        mem_waddr;
    logic [63:0]       mem_wdata;
    logic [EMIT_W-1:0] n_emit_idx;

    logic              in_acc, in_opt, start_emit, load_out;
    logic [7:0]        b;
    logic [7:0]        cookie_byte;
    logic [63:0]       word;

    assign b           = i_payload_byte;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = r_emit_active;
    assign o_cfg_ready = 1'b1;
    assign in_opt      = (r_pos >= POS_W'(HDR_LEN)) && (r_pos < POS_W'(POS_MAX));
    assign load_out    = r_emit_active && (!r_out_valid || !i_out_stall);

    always_comb begin
        case (r_pos[1:0])
            2'd0:    cookie_byte = MAGIC_COOKIE[31:24];
            2'd1:    cookie_byte = MAGIC_COOKIE[23:16];
            2'd2:    cookie_byte = MAGIC_COOKIE[15:8];
            default: cookie_byte = MAGIC_COOKIE[7:0];
        endcase
    end

    // option walk
    always_comb begin
        n_phase    = r_phase;
        n_skip     = r_skip;
        n_req_type = r_req_type;
        n_done     = r_done;
        if (in_opt && !r_done) begin
            case (r_phase)
                PH_CODE: begin
                    if (b == OPT_END) begin
                        n_done = 1'b1;
                    end else if (b != OPT_PAD) begin
                        n_phase = PH_LEN;
                        n_skip  = {7'd0, b == OPT_MSG_TYPE};
                    end
                end
                PH_LEN: begin
                    n_skip = b;
                    if (r_skip == 8'd1) begin
                        n_phase = PH_VAL53;
                    end else begin
                        n_phase = (b == 8'd0) ? PH_CODE : PH_SKIP;
                    end
                end
                PH_VAL53: begin
                    n_req_type = b;
                    if (r_skip == 8'd0) begin
                        n_phase = PH_CODE;
                        if (b == OPT_END) begin
                            n_done = 1'b1;
                        end else if (b != OPT_PAD) begin
                            n_phase = PH_LEN;
                            n_skip  = {7'd0, b == OPT_MSG_TYPE};
                        end
                    end else begin
                        n_skip  = r_skip - 8'd1;
                        n_phase = (r_skip == 8'd1) ? PH_CODE : PH_SKIP;
                    end
                end
                default: begin
                    n_skip = r_skip - 8'd1;
                    if (r_skip == 8'd1) begin
                        n_phase = PH_CODE;
                    end
                end
            endcase
        end
    end

    always_comb begin
        n_hdr_ok = r_hdr_ok;
        if (r_pos == POS_W'(0) && b != OP_BOOTREQUEST) begin
            n_hdr_ok = 1'b0;
        end
        if (r_pos >= POS_W'(236) && r_pos < POS_W'(HDR_LEN) && b != cookie_byte) begin
            n_hdr_ok = 1'b0;
        end
        n_pos = (r_pos < POS_W'(POS_MAX)) ? r_pos + POS_W'(1) : r_pos;
        n_hw_sr = {r_hw_sr[55:0], b};
        start_emit = i_end_of_packet && (r_pos >= POS_W'(HDR_LEN - 1)) && n_hdr_ok &&
                     (n_req_type == MSG_DISCOVER || n_req_type == MSG_REQUEST);
    end

    // chaddr store, entries laid out as reply words 3..5 at address idx[1:0]
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = 2'd3;
        mem_wdata = {32'h0, n_hw_sr[31:0]};
        if (in_acc) begin
            if (r_pos == POS_W'(31)) begin
                mem_we = 1'b1;
            end else if (r_pos == POS_W'(39)) begin
                mem_we    = 1'b1;
                mem_waddr = 2'd0;
                mem_wdata = n_hw_sr;
            end else if (r_pos == POS_W'(43)) begin
                mem_we    = 1'b1;
                mem_waddr = 2'd1;
                mem_wdata = {n_hw_sr[31:0], 32'h0};
            end
        end
    end

    always_comb begin
        if (in_acc && start_emit) begin
            n_emit_idx = '0;
        end else if (load_out) begin
            n_emit_idx = r_emit_idx + EMIT_W'(1);
        end else begin
            n_emit_idx = r_emit_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            hw_mem[mem_waddr] <= mem_wdata;
        end
        r_hw_rd <= hw_mem[n_emit_idx[1:0]];
    end

    always_comb begin
        case (r_emit_idx)
            6'd0:  word = {OP_BOOTREPLY, HTYPE_ETHER, HLEN_ETHER, 8'h00, r_xid};
            6'd1:  word = {16'h0, r_flags, 32'h0};
            6'd2:  word = {r_client, 32'h0};
            6'd3, 6'd4, 6'd5: word = r_hw_rd;
            6'd29: word = {32'h0, MAGIC_COOKIE};
            6'd30: word = {OPT_MSG_TYPE, OPT_LEN1, r_reply_type, OPT_SERVER_ID,
                           OPT_LEN4, r_server[31:8]};
            6'd31: word = {r_server[7:0], OPT_LEASE_TIME, OPT_LEN4, r_lease,
                           OPT_SUBNET_MASK};
            6'd32: word = {OPT_LEN4, r_mask, OPT_END, 16'h0};
            default: word = 64'h0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_server      <= RST_SERVER_ADDR;
            r_client      <= RST_CLIENT_ADDR;
            r_mask        <= RST_SUBNET_MASK;
            r_lease       <= RST_LEASE_SECS;
            r_pos         <= '0;
            r_hdr_ok      <= 1'b1;
            r_xid         <= '0;
            r_flags       <= '0;
            r_req_type    <= '0;
            r_phase       <= PH_CODE;
            r_skip        <= '0;
            r_done        <= 1'b0;
            r_emit_active <= 1'b0;
            r_emit_idx    <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_SERVER_ADDR: r_server <= i_cfg_data;
                    REG_CLIENT_ADDR: r_client <= i_cfg_data;
                    REG_SUBNET_MASK: r_mask   <= i_cfg_data;
                    REG_LEASE_SECS:  r_lease  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (in_acc) begin
                if (r_pos >= POS_W'(4) && r_pos < POS_W'(8)) begin
                    r_xid <= {r_xid[23:0], b};
                end
                if (r_pos >= POS_W'(10) && r_pos < POS_W'(12)) begin
                    r_flags <= {r_flags[7:0], b};
                end
                if (i_end_of_packet) begin
                    r_pos      <= '0;
                    r_hdr_ok   <= 1'b1;
                    r_req_type <= '0;
                    r_phase    <= PH_CODE;
                    r_skip     <= '0;
                    r_done     <= 1'b0;
                    if (start_emit) begin
                        r_emit_active <= 1'b1;
                        r_reply_type  <= (n_req_type == MSG_DISCOVER) ? MSG_OFFER : MSG_ACK;
                    end
                end else begin
                    r_pos      <= n_pos;
                    r_hdr_ok   <= n_hdr_ok;
                    r_req_type <= n_req_type;
                    r_phase    <= n_phase;
                    r_skip     <= n_skip;
                    r_done     <= n_done;
                end
            end
            r_emit_idx <= n_emit_idx;
            if (load_out) begin
                r_out_valid <= 1'b1;
                r_out_word  <= word;
                r_out_vb    <= (r_emit_idx == LAST_WORD_IDX) ? VB_LAST : VB_FULL;
                r_out_last  <= (r_emit_idx == LAST_WORD_IDX);
                if (r_emit_idx == LAST_WORD_IDX) begin
                    r_emit_active <= 1'b0;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && r_pos >= POS_W'(28) && r_pos < POS_W'(44)) begin
            r_hw_sr <= n_hw_sr;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_reply_word  = r_out_word;
    assign o_valid_bytes = r_out_vb;
    assign o_last_word   = r_out_last;

    a_emit_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out && r_emit_idx == LAST_WORD_IDX) |=> !r_emit_active)
        else $error("reply sequencer ran past last word");

    a_emit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emit_active |-> (r_emit_idx <= LAST_WORD_IDX))
        else $error("reply word index out of range");

    a_hold_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_out_word)))
        else $error("stalled reply word changed");

    a_pos_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(POS_MAX))
        else $error("byte position beyond saturation");

    a_first_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && start_emit) |=> (r_emit_active && r_emit_idx == '0))
        else $error("reply did not start at word zero");

endmodule
